// ===== rtl/pba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pba_pkg
// mode and status codes of the page bitmap allocator
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_FREE    = 2'd1;
    localparam logic [1:0] MODE_RESERVE = 2'd2;
    localparam logic [1:0] MODE_RELEASE = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NO_FREE   = 2'd1;
    localparam logic [1:0] ST_REJECTED  = 2'd2;

    localparam int unsigned CFG_TOTAL_W = 13;
    localparam int unsigned COUNT_W     = 13;

endpackage : pba_pkg
`default_nettype wire

// ===== rtl/page_bitmap_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// next-fit page allocator over a used/free bitmap kept in an internal memory
// ----------------------------------------------------------------------------
// channel   direction  handshake                 word
// command   in         start high, busy low      i_mode, i_address, i_end_address
// result    out        o_valid for one cycle     o_page_address, o_status, counts
// config    in         i_cfg_wr_en               i_cfg_wr_data (total pages)
//
// the memory port sets the pace: a map word is read, then evaluated/written.
// alloc reduces the search pointer modulo the total, then reads and
// evaluates each map word scanned, then outputs; free reads, writes and
// outputs; a range reads and writes each map word touched, then outputs;
// a rejected free, an empty range or alloc with no pages goes straight to
// output. the result word shows in the cycle after the output step, and
// busy drops with it. reset: a clearing pass writes every map word to all
// ones, with busy high; config writes are taken throughout.
// the receiver cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module page_bitmap_allocator #(
    parameter int unsigned MAX_PAGES  = 4096,
    parameter int unsigned PAGE_BYTES = 4096
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [1:0]                      i_mode,
    input  wire logic [31:0]                     i_address,
    input  wire logic [31:0]                     i_end_address,
    output logic                                 o_valid,
    output logic [31:0]                          o_page_address,
    output logic [1:0]                           o_status,
    output logic [pba_pkg::COUNT_W-1:0]          o_free_count,
    output logic [pba_pkg::COUNT_W-1:0]          o_used_count,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [pba_pkg::CFG_TOTAL_W-1:0] i_cfg_wr_data
);
    import pba_pkg::*;

    localparam int unsigned MAP_WORDS = (MAX_PAGES + 31) / 32;
    localparam int unsigned WW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned NW = $clog2(MAX_PAGES + 1);   // page counts and indexes
    localparam int unsigned BW = $clog2(NW);
    localparam int unsigned LG = $clog2(PAGE_BYTES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MOD, S_ARD, S_AEV, S_RRD, S_REV, S_OUT
    } t_state;

    t_state               r_state;
    logic [CFG_TOTAL_W-1:0] r_total;
    logic [NW-1:0]        r_free;
    logic [NW-1:0]        r_search;
    logic [NW-1:0]        r_first;     // start page of scan or range
    logic [NW-1:0]        r_lastm1;    // last page (inclusive)
    logic [NW-1:0]        r_rem;
    logic [BW-1:0]        r_bit;
    logic [WW-1:0]        r_word;
    logic [WW:0]          r_cnt;
    logic                 r_firstvisit;
    logic                 r_make_used;
    logic [31:0]          r_rdata;
    logic [31:0]          r_mem [MAP_WORDS];

    logic                 r_valid;
    logic [31:0]          r_page_address;
    logic [1:0]           r_status;

    // effective total
    logic [31:0] tot32;
    logic [NW-1:0] tot;
    assign tot32 = (32'(r_total) > MAX_PAGES) ? MAX_PAGES : 32'(r_total);
    assign tot   = tot32[NW-1:0];

    // memory port controls
    logic          mem_we;
    logic [31:0]   mem_wdata;
    logic [WW-1:0] mem_raddr;
    logic          mem_re;

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
        if (mem_we) begin
            r_mem[r_word] <= mem_wdata;
        end
    end

    // word positions of the first and last page
    logic [31:0]   first32, lastm132;
    logic [WW-1:0] first_w, last_w;
    logic [4:0]    first_b, last_b;
    assign first32  = 32'(r_first);
    assign lastm132 = 32'(r_lastm1);
    assign first_w  = WW'(first32 >> 5);
    assign last_w   = WW'(lastm132 >> 5);
    assign first_b  = first32[4:0];
    assign last_b   = lastm132[4:0];

    // bits of the current word that lie inside [first, last]
    logic [31:0] lo_mask, hi_mask;
    assign hi_mask = (r_word == last_w) ? (32'hFFFF_FFFF >> (5'd31 - last_b)) : '1;

    // alloc: lowest free bit in the window
    logic [31:0] avail;
    logic [4:0]  sel_b;
    logic        found;
    always_comb begin
        if (r_state == S_AEV) begin
            lo_mask = r_firstvisit ? (32'hFFFF_FFFF << first_b) : '1;
        end else begin
            lo_mask = (r_word == first_w) ? (32'hFFFF_FFFF << first_b) : '1;
        end
        avail = ~r_rdata & lo_mask & hi_mask;
        found = |avail;
        sel_b = '0;
        for (int i = 31; i >= 0; i--) begin
            if (avail[i]) begin
                sel_b = 5'(i);
            end
        end
    end

    // range: changed bits and their count
    logic [31:0] rmask, changed, new_word;
    logic [5:0]  nchg;
    always_comb begin
        rmask    = lo_mask & hi_mask;
        changed  = r_make_used ? (rmask & ~r_rdata) : (rmask & r_rdata);
        new_word = r_make_used ? (r_rdata | rmask) : (r_rdata & ~rmask);
        nchg     = '0;
        for (int i = 0; i < 32; i++) begin
            nchg = nchg + 6'(changed[i]);
        end
    end

    // saturating count updates
    logic [31:0] free32, inc32;
    logic [NW-1:0] free_dec, free_inc;
    assign free32   = 32'(r_free);
    assign inc32    = free32 + 32'(nchg);
    assign free_dec = (free32 >= 32'(nchg)) ? NW'(free32 - 32'(nchg)) : '0;
    assign free_inc = (inc32 > MAX_PAGES) ? NW'(MAX_PAGES) : NW'(inc32);

    // command decode
    logic [31:0] cmd_first;
    logic [32:0] cmd_last, cmd_lastc;
    logic        cmd_aligned;
    assign cmd_first   = i_address >> LG;
    assign cmd_aligned = (i_address & 32'(PAGE_BYTES - 1)) == '0;
    assign cmd_last    = (33'(i_end_address) + 33'(PAGE_BYTES - 1)) >> LG;
    assign cmd_lastc   = (cmd_last > 33'(tot)) ? 33'(tot) : cmd_last;

    // pointer modulo step
    logic [31:0] search32;
    logic [NW:0] mod_t, mod_r;
    assign search32 = 32'(r_search);
    assign mod_t = {r_rem, search32[r_bit]};
    assign mod_r = (mod_t >= (NW+1)'(tot)) ? (mod_t - (NW+1)'(tot)) : mod_t;

    logic [31:0] page32;
    assign page32 = (32'(r_word) << 5) | 32'(sel_b);

    always_comb begin
        mem_re    = (r_state == S_ARD) || (r_state == S_RRD);
        mem_raddr = r_word;
        mem_we    = 1'b0;
        mem_wdata = new_word;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '1;
            end
            S_AEV: begin
                mem_we    = found;
                mem_wdata = r_rdata | (32'd1 << sel_b);
            end
            S_REV: begin
                mem_we    = 1'b1;
            end
            default: begin
                mem_we    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_total  <= CFG_TOTAL_W'(4096);
            r_free   <= '0;
            r_search <= '0;
            r_word   <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_wr_en) begin
                r_total <= i_cfg_wr_data;
            end
            case (r_state)
                S_CLEAR: begin
                    // fill the map with used pages
                    if (r_word == WW'(MAP_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_word <= r_word + 1'b1;
                    end
                end
                S_IDLE: begin
                    r_page_address <= '0;
                    r_status       <= ST_DONE;
                    if (start) begin
                        case (i_mode)
                            MODE_ALLOC: begin
                                if (tot == '0) begin
                                    r_status <= ST_NO_FREE;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_rem   <= '0;
                                    r_bit   <= BW'(NW - 1);
                                    r_state <= S_MOD;
                                end
                            end
                            MODE_FREE: begin
                                if (!cmd_aligned || cmd_first >= 32'(tot)) begin
                                    r_status <= ST_REJECTED;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_first     <= NW'(cmd_first);
                                    r_lastm1    <= NW'(cmd_first);
                                    r_word      <= WW'(cmd_first >> 5);
                                    r_make_used <= 1'b0;
                                    r_state     <= S_RRD;
                                end
                            end
                            default: begin
                                // reserve or release a range
                                if (33'(cmd_first) >= cmd_lastc) begin
                                    r_state <= S_OUT;
                                end else begin
                                    r_first     <= NW'(cmd_first);
                                    r_lastm1    <= NW'(cmd_lastc - 33'd1);
                                    r_word      <= WW'(cmd_first >> 5);
                                    r_make_used <= (i_mode == MODE_RESERVE);
                                    r_state     <= S_RRD;
                                end
                            end
                        endcase
                    end
                end
                S_MOD: begin
                    // one restoring step of search pointer modulo total
                    r_rem <= NW'(mod_r);
                    if (r_bit == '0) begin
                        r_first      <= NW'(mod_r);
                        r_lastm1     <= NW'(tot - 1'b1);
                        r_word       <= WW'(32'(NW'(mod_r)) >> 5);
                        r_cnt        <= '0;
                        r_firstvisit <= 1'b1;
                        r_state      <= S_ARD;
                    end else begin
                        r_bit <= r_bit - 1'b1;
                    end
                end
                S_ARD: begin
                    r_state <= S_AEV;
                end
                S_AEV: begin
                    r_firstvisit <= 1'b0;
                    if (found) begin
                        r_free         <= (r_free != '0) ? r_free - 1'b1 : r_free;
                        r_search       <= NW'(page32 + 32'd1);
                        r_page_address <= page32 << LG;
                        r_state        <= S_OUT;
                    end else if (r_cnt == {1'b0, last_w} + 1'b1) begin
                        // every word visited, start word twice
                        r_status <= ST_NO_FREE;
                        r_state  <= S_OUT;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_word  <= (r_word == last_w) ? '0 : r_word + 1'b1;
                        r_state <= S_ARD;
                    end
                end
                S_RRD: begin
                    r_state <= S_REV;
                end
                S_REV: begin
                    r_free <= r_make_used ? free_dec : free_inc;
                    if (r_word == last_w) begin
                        r_state <= S_OUT;
                    end else begin
                        r_word  <= r_word + 1'b1;
                        r_state <= S_RRD;
                    end
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // counts shown with the result word
    logic [31:0] fc32, uc32;
    assign fc32 = 32'(r_free);
    assign uc32 = (tot > r_free) ? 32'(tot - r_free) : '0;

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_page_address = r_page_address;
    assign o_status       = r_status;
    assign o_free_count   = fc32[COUNT_W-1:0];
    assign o_used_count   = uc32[COUNT_W-1:0];

endmodule : page_bitmap_allocator
`default_nettype wire
